/* hdl/falbc_pkg.sv */
// shared types and constants of the fully associative lru block cache
package falbc_pkg;

  localparam int DISK_W  = 4;
  localparam int BLOCK_W = 8;
  localparam int WORD_W  = 64;
  localparam int STAMP_W = 32;
  localparam int CNT_W32 = 32;
  localparam int ACT_W   = 2;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 1'd1;

  localparam logic [CFG_W-1:0] ENTRIES_MIN = 13'd2;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [DISK_W-1:0]  disk;
    logic [BLOCK_W-1:0] block;
    logic [WORD_W-1:0]  data_word;
    logic               word_last;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [WORD_W-1:0]  read_word;
    logic               last;
    logic [CNT_W32-1:0] hit_count;
    logic [CNT_W32-1:0] query_count;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic [DISK_W-1:0]  disk;
    logic [BLOCK_W-1:0] blk;
    logic [STAMP_W-1:0] stamp;
  } tag_ent_t;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic scan_init;
    logic scan_step;
    logic take;
    logic use_victim;
    logic copy_step;
    logic rd_word;
    logic emit;
    logic emit_status;
    logic emit_word;
    logic stage_clr;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             wlast;
    logic             en;
    logic             en_rise;
    logic             cmp_match;
    logic             scan_done;
    logic             copy_done;
    logic             clr_last;
    logic             out_full;
    logic             out_busy;
    logic             word_final;
  } stat_t;

endpackage

/* hdl/fully_associative_lru_block_cache_unit.sv */
// top level of the fully associative lru block cache
//
// in channel: one beat per request (lookup, insert or update word), valid/stall.
// out channel: result beats, valid/stall; last marks the final beat of a request.
// insert and update words are staged one beat each; only the beat with word_last
// commits and gives one result. a lookup hit returns BLOCK_WORDS beats, a miss one.
// cfg port: write enable, index and data; index 0 enabled, index 1 entries_in_use.
// timing: a request is taken only while the output register is empty. the tag
// scan reads one entry a cycle from the tag memory; a commit copies the staged
// block into each written entry; a hit reads each word from the data memory and
// then sends it, waiting while the output beat is stalled.
// reset and enabling the cache run a clearing pass over all MAX_ENTRIES entries of the
// tag memory; in_stall is high during it.
// when out_stall is high the output beat holds and the block waits for it.
module fully_associative_lru_block_cache_unit #(
  parameter int MAX_ENTRIES = 4096,
  parameter int BLOCK_WORDS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  falbc_pkg::in_item_t             in_beat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output falbc_pkg::out_item_t            out_beat,
  input  logic                            cfg_we,
  input  logic [falbc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [falbc_pkg::CFG_W-1:0]     cfg_wdata
);
  import falbc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  falbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  falbc_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .BLOCK_WORDS (BLOCK_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_beat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !out_valid)
    else $error("request taken while a result is pending");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit && cmd.emit_word))
    else $error("two result sources in one cycle");

  a_match_halts: assert property (@(posedge clk) disable iff (!rst_n)
    stat.cmp_match |-> !cmd.scan_step)
    else $error("scan advanced past a match");

  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open during clearing pass");

endmodule

/* hdl/falbc_ctrl.sv */
// controller state machine of the block cache
module falbc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  falbc_pkg::stat_t stat,
  output falbc_pkg::cmd_t  cmd
);
  import falbc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DECIDE, S_SCAN, S_COPY, S_RD, S_SEND
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall   = stat.out_full;
        cmd.accept = in_valid && !stat.out_full;
        if (cmd.accept) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        case (stat.act)
          ACT_LOOKUP: begin
            if (stat.en) begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end else begin
              cmd.emit        = 1'b1;
              cmd.emit_status = 1'b1;
              state_nxt       = S_IDLE;
            end
          end
          ACT_INSERT, ACT_UPDATE: begin
            if (!stat.wlast) begin
              state_nxt = S_IDLE;
            end else if (!stat.en) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = (stat.act == ACT_INSERT);
              cmd.stage_clr   = 1'b1;
              state_nxt       = S_IDLE;
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
          end
          default: begin
            cmd.emit        = 1'b1;
            cmd.emit_status = 1'b1;
            state_nxt       = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.cmp_match) begin
          case (stat.act)
            ACT_LOOKUP: begin
              cmd.take  = 1'b1;
              state_nxt = S_RD;
            end
            ACT_UPDATE: begin
              cmd.take  = 1'b1;
              state_nxt = S_COPY;
            end
            default: begin
              // duplicate tag on insert
              cmd.emit        = 1'b1;
              cmd.emit_status = 1'b1;
              cmd.stage_clr   = 1'b1;
              state_nxt       = S_IDLE;
            end
          endcase
        end else if (stat.scan_done) begin
          case (stat.act)
            ACT_LOOKUP: begin
              cmd.emit        = 1'b1;
              cmd.emit_status = 1'b1;
              state_nxt       = S_IDLE;
            end
            ACT_UPDATE: begin
              cmd.emit      = 1'b1;
              cmd.stage_clr = 1'b1;
              state_nxt     = S_IDLE;
            end
            default: begin
              cmd.take       = 1'b1;
              cmd.use_victim = 1'b1;
              state_nxt      = S_COPY;
            end
          endcase
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (stat.copy_done) begin
          if (stat.act == ACT_UPDATE) begin
            state_nxt = S_SCAN;
          end else begin
            cmd.emit      = 1'b1;
            cmd.stage_clr = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_RD: begin
        cmd.rd_word = 1'b1;
        state_nxt   = S_SEND;
      end
      S_SEND: begin
        if (!stat.out_busy) begin
          cmd.emit_word = 1'b1;
          state_nxt     = stat.word_final ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // enabling the cache wipes every entry
    if (stat.en_rise) begin
      cmd.accept    = 1'b0;
      cmd.clr_step  = 1'b0;
      cmd.scan_init = 1'b1;
      in_stall      = 1'b1;
      state_nxt     = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/falbc_dp.sv */
// datapath of the block cache: tag and data memories, staging, counters, output register
module falbc_dp #(
  parameter int MAX_ENTRIES = 4096,
  parameter int BLOCK_WORDS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  falbc_pkg::in_item_t                 in_beat,
  input  logic                                out_stall,
  output logic                                out_valid,
  output falbc_pkg::out_item_t                out_beat,
  input  logic                                cfg_we,
  input  logic [falbc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [falbc_pkg::CFG_W-1:0]         cfg_wdata,
  input  falbc_pkg::cmd_t                     cmd,
  output falbc_pkg::stat_t                    stat
);
  import falbc_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SC_W  = $clog2(BLOCK_WORDS + 1);
  localparam int SI_W  = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int DA_W  = $clog2(MAX_ENTRIES * BLOCK_WORDS);

  tag_ent_t          tag_mem [MAX_ENTRIES];
  logic [WORD_W-1:0] data_mem [MAX_ENTRIES * BLOCK_WORDS];
  logic [WORD_W-1:0] stage_mem [BLOCK_WORDS];

  logic               enabled_r;
  logic [CNT_W-1:0]   entries_r;
  logic [ACT_W-1:0]   act_r;
  logic [DISK_W-1:0]  disk_r;
  logic [BLOCK_W-1:0] blk_r;
  logic               wlast_r;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               cmp_vld_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  tag_ent_t           tag_q_r;
  logic               inv_found_r, inv_found_nxt;
  logic [IDX_W-1:0]   inv_idx_r, inv_idx_nxt;
  logic [STAMP_W-1:0] best_time_r, best_time_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [IDX_W-1:0]   sel_idx_r;
  logic [SC_W-1:0]    word_r, word_nxt;
  logic [SC_W-1:0]    stage_cnt_r, stage_cnt_nxt;
  logic               wr_v_r;
  logic [SI_W-1:0]    wr_w_r;
  logic [WORD_W-1:0]  stage_q_r;
  logic [WORD_W-1:0]  data_q_r;
  logic [STAMP_W-1:0] clk_r;
  logic [CNT_W32-1:0] hits_r, queries_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r;

  logic               issue;
  logic               stage_wr;
  logic               copy_rd;
  logic [IDX_W-1:0]   victim_idx;
  logic [IDX_W-1:0]   take_idx;
  logic               tw_en;
  logic [IDX_W-1:0]   tw_idx;
  tag_ent_t           tw_data;
  logic               load;

  function automatic logic [DA_W-1:0] daddr(input logic [IDX_W-1:0] idx,
                                            input logic [SI_W-1:0] w);
    logic [DA_W-1:0] base;
    base  = DA_W'(DA_W'(idx) * DA_W'(BLOCK_WORDS));
    daddr = base + DA_W'(w);
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      entries_r <= CNT_W'(ENTRIES_MIN);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ENABLED: enabled_r <= cfg_wdata[0];
        REG_ENTRIES: begin
          if (cfg_wdata >= ENTRIES_MIN && 32'(cfg_wdata) <= 32'(MAX_ENTRIES))
            entries_r <= CNT_W'(cfg_wdata);
        end
        default: ;
      endcase
    end
  end

  assign issue      = rd_idx_r < entries_r;
  assign victim_idx = inv_found_r ? inv_idx_r : best_idx_r;
  assign take_idx   = cmd.use_victim ? victim_idx : cmp_idx_r;
  assign stage_wr   = cmd.accept
                   && (in_beat.action == ACT_INSERT || in_beat.action == ACT_UPDATE)
                   && stage_cnt_r < SC_W'(BLOCK_WORDS);
  assign copy_rd    = cmd.copy_step && word_r < SC_W'(BLOCK_WORDS);
  assign load       = cmd.emit || cmd.emit_word;

  always_comb begin
    tw_en   = 1'b0;
    tw_idx  = take_idx;
    tw_data = '0;
    if (cmd.clr_step) begin
      tw_en  = 1'b1;
      tw_idx = rd_idx_r[IDX_W-1:0];
    end else if (cmd.take) begin
      tw_en         = 1'b1;
      tw_data.valid = 1'b1;
      tw_data.disk  = disk_r;
      tw_data.blk   = blk_r;
      tw_data.stamp = clk_r + 1'b1;
    end
  end

  always_comb begin
    rd_idx_nxt    = rd_idx_r;
    inv_found_nxt = inv_found_r;
    inv_idx_nxt   = inv_idx_r;
    best_time_nxt = best_time_r;
    best_idx_nxt  = best_idx_r;
    word_nxt      = word_r;
    stage_cnt_nxt = stage_cnt_r;
    if (cmd.scan_init) begin
      rd_idx_nxt    = '0;
      inv_found_nxt = 1'b0;
    end else if (cmd.clr_step || (cmd.scan_step && issue)) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end
    // victim search: first free entry, else oldest stamp with first on a tie
    if (cmp_vld_r) begin
      if (!inv_found_r && !tag_q_r.valid) begin
        inv_found_nxt = 1'b1;
        inv_idx_nxt   = cmp_idx_r;
      end
      if (cmp_idx_r == '0 || tag_q_r.stamp < best_time_r) begin
        best_time_nxt = tag_q_r.stamp;
        best_idx_nxt  = cmp_idx_r;
      end
    end
    if (cmd.take) word_nxt = '0;
    else if (copy_rd || cmd.emit_word) word_nxt = word_r + 1'b1;
    if (cmd.stage_clr) stage_cnt_nxt = '0;
    else if (stage_wr) stage_cnt_nxt = stage_cnt_r + 1'b1;
    if (load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      inv_found_r <= 1'b0;
      word_r      <= '0;
      stage_cnt_r <= '0;
      wr_v_r      <= 1'b0;
      clk_r       <= '0;
      hits_r      <= '0;
      queries_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_idx_r    <= rd_idx_nxt;
      cmp_vld_r   <= cmd.scan_step && issue;
      inv_found_r <= inv_found_nxt;
      word_r      <= word_nxt;
      stage_cnt_r <= stage_cnt_nxt;
      wr_v_r      <= copy_rd;
      out_valid_r <= out_valid_nxt;
      if (cmd.take) begin
        clk_r <= clk_r + 1'b1;
        if (act_r == ACT_LOOKUP) hits_r <= hits_r + 1'b1;
      end
      if (cmd.accept && in_beat.action == ACT_LOOKUP) queries_r <= queries_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    inv_idx_r   <= inv_idx_nxt;
    best_time_r <= best_time_nxt;
    best_idx_r  <= best_idx_nxt;
    cmp_idx_r   <= rd_idx_r[IDX_W-1:0];
    if (cmd.accept) begin
      act_r   <= in_beat.action;
      disk_r  <= in_beat.disk;
      blk_r   <= in_beat.block;
      wlast_r <= in_beat.word_last;
    end
    if (cmd.take) sel_idx_r <= take_idx;
    if (copy_rd) wr_w_r <= word_r[SI_W-1:0];
    if (load) begin
      out_r.status      <= cmd.emit ? cmd.emit_status : 1'b0;
      out_r.read_word   <= cmd.emit ? '0 : data_q_r;
      out_r.last        <= cmd.emit ? 1'b1 : (word_r == SC_W'(BLOCK_WORDS - 1));
      out_r.hit_count   <= hits_r;
      out_r.query_count <= queries_r;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (tw_en) tag_mem[tw_idx] <= tw_data;
    if (cmd.scan_step && issue) tag_q_r <= tag_mem[rd_idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (stage_wr) stage_mem[stage_cnt_r[SI_W-1:0]] <= in_beat.data_word;
    if (copy_rd) stage_q_r <= stage_mem[word_r[SI_W-1:0]];
  end

  always_ff @(posedge clk) begin
    // words past the staged count commit as zero
    if (wr_v_r)
      data_mem[daddr(sel_idx_r, wr_w_r)] <= (SC_W'(wr_w_r) < stage_cnt_r) ? stage_q_r : '0;
    if (cmd.rd_word) data_q_r <= data_mem[daddr(sel_idx_r, word_r[SI_W-1:0])];
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  always_comb begin
    stat            = '0;
    stat.act        = act_r;
    stat.wlast      = wlast_r;
    stat.en         = enabled_r;
    stat.en_rise    = cfg_we && cfg_idx == REG_ENABLED && cfg_wdata[0] && !enabled_r;
    stat.cmp_match  = cmp_vld_r && tag_q_r.valid && tag_q_r.disk == disk_r
                      && tag_q_r.blk == blk_r;
    stat.scan_done  = !cmp_vld_r && !issue;
    stat.copy_done  = wr_v_r && wr_w_r == SI_W'(BLOCK_WORDS - 1);
    stat.clr_last   = rd_idx_r == CNT_W'(MAX_ENTRIES - 1);
    stat.out_full   = out_valid_r;
    stat.out_busy   = out_valid_r && out_stall;
    stat.word_final = word_r == SC_W'(BLOCK_WORDS - 1);
  end

endmodule

/* verif/testbench.sv */
// self-checking testbench of the fully associative lru block cache
`timescale 1ns / 100ps

module testbench;
  import falbc_pkg::*;

  localparam int NENT  = 4096;
  localparam int BWORDS = 32;
  localparam logic [ACT_W-1:0] ACT_BAD = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_beat = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_beat;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_ENABLED;
  logic [CFG_W-1:0] cfg_wdata = '0;

  fully_associative_lru_block_cache_unit uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_beat(in_beat), .out_valid(out_valid), .out_stall(out_stall),
    .out_beat(out_beat), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted cache state
  logic             cache_on;
  int unsigned      ways_used;
  logic             way_valid [NENT];
  logic [DISK_W-1:0]  way_disk [NENT];
  logic [BLOCK_W-1:0] way_block [NENT];
  logic [31:0]      way_stamp [NENT];
  logic [WORD_W-1:0] way_data [NENT][BWORDS];
  logic [WORD_W-1:0] stage_buf [BWORDS];
  int unsigned      staged;
  logic [31:0]      stamp_clock, hit_total, lookup_total;

  out_item_t expected_beats[$];
  int errors = 0;
  int burst_left = 0;
  logic [3:0] stall_mode = '0;
  logic [DISK_W-1:0] pool_disk [8];
  logic [BLOCK_W-1:0] pool_block [8];

  function automatic out_item_t mk_beat(logic st, logic [WORD_W-1:0] w, logic lst);
    out_item_t r;
    r.status = st; r.read_word = w; r.last = lst;
    r.hit_count = hit_total; r.query_count = lookup_total;
    return r;
  endfunction

  function automatic void commit_way(int unsigned i);
    for (int w = 0; w < BWORDS; w++) way_data[i][w] = (w < staged) ? stage_buf[w] : '0;
    stamp_clock++;
    way_stamp[i] = stamp_clock;
  endfunction

  function automatic void predict_cache(in_item_t it);
    int victim;
    logic hit;
    victim = -1;
    hit = 1'b0;
    if (it.action == ACT_LOOKUP) begin
      lookup_total++;
      if (cache_on) begin
        for (int i = 0; i < ways_used && !hit; i++) begin
          if (way_valid[i] && way_disk[i] == it.disk && way_block[i] == it.block) begin
            hit = 1'b1;
            hit_total++;
            stamp_clock++;
            way_stamp[i] = stamp_clock;
            for (int w = 0; w < BWORDS; w++)
              expected_beats.push_back(mk_beat(1'b0, way_data[i][w], w == BWORDS - 1));
          end
        end
      end
      if (!hit) expected_beats.push_back(mk_beat(1'b1, '0, 1'b1));
      return;
    end
    if (it.action == ACT_BAD) begin
      expected_beats.push_back(mk_beat(1'b1, '0, 1'b1));
      return;
    end
    if (staged < BWORDS) begin
      stage_buf[staged] = it.data_word;
      staged++;
    end
    if (!it.word_last) return;
    if (it.action == ACT_UPDATE) begin
      if (cache_on)
        for (int i = 0; i < ways_used; i++)
          if (way_valid[i] && way_disk[i] == it.disk && way_block[i] == it.block)
            commit_way(i);
      staged = 0;
      expected_beats.push_back(mk_beat(1'b0, '0, 1'b1));
      return;
    end
    if (!cache_on) begin
      staged = 0;
      expected_beats.push_back(mk_beat(1'b1, '0, 1'b1));
      return;
    end
    for (int i = 0; i < ways_used; i++)
      if (way_valid[i] && way_disk[i] == it.disk && way_block[i] == it.block) hit = 1'b1;
    if (hit) begin
      staged = 0;
      expected_beats.push_back(mk_beat(1'b1, '0, 1'b1));
      return;
    end
    for (int i = 0; i < ways_used && victim < 0; i++)
      if (!way_valid[i]) victim = i;
    if (victim < 0) begin
      victim = 0;
      for (int i = 1; i < ways_used; i++)
        if (way_stamp[i] < way_stamp[victim]) victim = i;
    end
    way_disk[victim] = it.disk;
    way_block[victim] = it.block;
    way_valid[victim] = 1'b1;
    commit_way(victim);
    staged = 0;
    expected_beats.push_back(mk_beat(1'b0, '0, 1'b1));
  endfunction

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    out_item_t exp_b;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual %h", $time, out_beat);
        errors++;
      end else begin
        exp_b = expected_beats.pop_front();
        if (out_beat.status !== exp_b.status) begin
          $display("%0t status: expected %0d actual %0d", $time, exp_b.status, out_beat.status);
          errors++;
        end
        if (out_beat.read_word !== exp_b.read_word) begin
          $display("%0t read_word: expected %h actual %h", $time, exp_b.read_word,
                   out_beat.read_word);
          errors++;
        end
        if (out_beat.last !== exp_b.last) begin
          $display("%0t last: expected %0d actual %0d", $time, exp_b.last, out_beat.last);
          errors++;
        end
        if (out_beat.hit_count !== exp_b.hit_count) begin
          $display("%0t hit_count: expected %0d actual %0d", $time, exp_b.hit_count,
                   out_beat.hit_count);
          errors++;
        end
        if (out_beat.query_count !== exp_b.query_count) begin
          $display("%0t query_count: expected %0d actual %0d", $time, exp_b.query_count,
                   out_beat.query_count);
          errors++;
        end
      end
    end
    stall_mode <= stall_mode + 4'd1;
    // stretches without stall alternate with random stalling
    out_stall <= stall_mode[3] ? ($urandom_range(0, 2) == 0) : 1'b0;
  end

  task automatic pause_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // valid stays high between beats of a burst
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        pause_cycles(gap);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_beat <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_cache(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    // a clearing pass can still run on after the last beat
    pause_cycles(NENT + 200);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ENABLED) begin
      if (val[0] && !cache_on)
        for (int i = 0; i < NENT; i++) begin
          way_valid[i] = 1'b0;
          way_stamp[i] = '0;
        end
      cache_on = val[0];
    end else if (val >= 2 && val <= NENT) begin
      ways_used = 32'(val);
    end
    // enabling starts a clearing pass; in_stall covers it
    pause_cycles(4);
  endtask

  function automatic in_item_t mk_item(logic [ACT_W-1:0] a, logic [DISK_W-1:0] d,
                                       logic [BLOCK_W-1:0] b, logic [WORD_W-1:0] w,
                                       logic l);
    in_item_t it;
    it.action = a; it.disk = d; it.block = b; it.data_word = w; it.word_last = l;
    return it;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // stage nwords words and commit with the given action
  task automatic send_block(logic [ACT_W-1:0] a, logic [DISK_W-1:0] d,
                            logic [BLOCK_W-1:0] b, int nwords);
    for (int w = 0; w < nwords; w++)
      send_item(mk_item(a, d, b, rand_word(), w == nwords - 1));
  endtask

  task automatic test_disabled();
    send_item(mk_item(ACT_LOOKUP, 4'hF, 8'hFF, '0, 1'b0));
    send_block(ACT_INSERT, 4'h0, 8'h00, 2);
    send_block(ACT_UPDATE, 4'h0, 8'h00, 1);
    send_item(mk_item(ACT_BAD, 4'h3, 8'h33, '1, 1'b1));
    wait_drained();
  endtask

  task automatic test_directed();
    write_reg(REG_ENABLED, 13'd1);
    write_reg(REG_ENTRIES, 13'd0);     // ignored
    write_reg(REG_ENTRIES, 13'd8191);  // ignored
    send_item(mk_item(ACT_INSERT, 4'h0, 8'h00, '1, 1'b1)); // short block
    send_item(mk_item(ACT_LOOKUP, 4'h0, 8'h00, '0, 1'b0));
    send_item(mk_item(ACT_INSERT, 4'h0, 8'h00, '0, 1'b1)); // duplicate
    send_block(ACT_INSERT, 4'hF, 8'hFF, BWORDS + 2);        // overflow
    send_item(mk_item(ACT_LOOKUP, 4'hF, 8'hFF, '0, 1'b0));
    send_item(mk_item(ACT_INSERT, 4'h1, 8'h01, 64'h0123_4567_89AB_CDEF, 1'b0));
    send_item(mk_item(ACT_UPDATE, 4'h0, 8'h00, 64'hFEDC_BA98_7654_3210, 1'b1)); // mixed
    send_item(mk_item(ACT_INSERT, 4'h5, 8'hA5, '1, 1'b1)); // evicts lru
    send_item(mk_item(ACT_LOOKUP, 4'hF, 8'hFF, '0, 1'b0));
    send_item(mk_item(ACT_LOOKUP, 4'h0, 8'h00, '0, 1'b0));
    send_item(mk_item(ACT_UPDATE, 4'h9, 8'h99, '0, 1'b1));  // no match
    send_item(mk_item(ACT_BAD, 4'hF, 8'hFF, '0, 1'b0));
    // leave idle so the sender's pause covers an empty pipeline
    wait_drained();
  endtask

  task automatic test_random(int count, int pool_n);
    in_item_t it;
    int k, sel;
    for (int i = 0; i < 8; i++) begin
      pool_disk[i] = DISK_W'($urandom());
      pool_block[i] = BLOCK_W'($urandom());
    end
    k = 0;
    while (k < count) begin
      sel = $urandom_range(0, pool_n - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_item(mk_item(ACT_LOOKUP, pool_disk[sel], pool_block[sel], rand_word(),
                            1'($urandom_range(0, 1))));
          k++;
        end
        4, 5: begin
          send_block(ACT_INSERT, pool_disk[sel], pool_block[sel], $urandom_range(1, 3));
          k += 2;
        end
        6: begin
          send_block(ACT_UPDATE, pool_disk[sel], pool_block[sel], $urandom_range(1, 3));
          k += 2;
        end
        7: begin
          it = in_item_t'($bits(in_item_t)'({$urandom(), $urandom(), $urandom()}));
          send_item(it);
          k++;
        end
        default: begin
          send_item(mk_item(ACT_LOOKUP, DISK_W'($urandom()), BLOCK_W'($urandom()),
                            rand_word(), 1'b0));
          k++;
        end
      endcase
    end
    wait_drained();
  endtask

  task automatic test_settings();
    write_reg(REG_ENTRIES, 13'd4);
    test_random(20, 8);
    write_reg(REG_ENABLED, 13'd0);
    test_random(6, 4);
    write_reg(REG_ENABLED, 13'd1);
    write_reg(REG_ENTRIES, 13'd4096);
    test_random(20, 8);
    write_reg(REG_ENTRIES, 13'd2);
    test_random(20, 6);
  endtask

  initial begin
    cache_on = 1'b0;
    ways_used = 2;
    staged = 0;
    stamp_clock = '0;
    hit_total = '0;
    lookup_total = '0;
    for (int i = 0; i < NENT; i++) begin
      way_valid[i] = 1'b0;
      way_stamp[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_disabled();
    test_directed();
    test_settings();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
